@@ design/boc_pkg.sv @@
// Shared widths, register indexes and beat type for the body obfuscate/checksum block.
package boc_pkg;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 32;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 2;
  localparam int PHASE_W = 8;
  localparam int CRC_BITS_PER_BYTE = 8;

  localparam logic [IDX_W-1:0] REG_POLYNOMIAL   = 2'd0;
  localparam logic [IDX_W-1:0] REG_BYTE_OFFSET  = 2'd1;
  localparam logic [IDX_W-1:0] REG_CYCLE_LENGTH = 2'd2;
  localparam logic [IDX_W-1:0] REG_DECODE_MODE  = 2'd3;

  localparam logic [CRC_W-1:0]   POLY_RESET  = 32'hEDB8_8320;
  localparam logic [BYTE_W-1:0]  OFFSET_RESET = 8'd0;
  localparam logic [PHASE_W-1:0] CYCLE_RESET  = 8'd1;

  // One result beat: fields are declared highest first, so result_byte is the lowest when packed.
  typedef struct packed {
    logic              sum_valid;
    logic [CRC_W-1:0]  checksum;
    logic [BYTE_W-1:0] result_byte;
  } boc_beat_t;

endpackage

@@ design/boc_crc_step.sv @@
// One byte of the reflected, sign-keeping table CRC, with the table entry built inline.
module boc_crc_step import boc_pkg::*; (
  input  logic [CRC_W-1:0]  acc,
  input  logic [BYTE_W-1:0] plain,
  input  logic [CRC_W-1:0]  poly,
  output logic [CRC_W-1:0]  acc_next
);

  logic [CRC_W-1:0] v [CRC_BITS_PER_BYTE+1];
  logic [CRC_W-1:0] sh [CRC_BITS_PER_BYTE];

  always_comb begin
    v[0] = {{(CRC_W-BYTE_W){1'b0}}, acc[BYTE_W-1:0] ^ plain};
    for (int k = 0; k < CRC_BITS_PER_BYTE; k++) begin
      // arithmetic shift: top bit refills itself
      sh[k] = {v[k][CRC_W-1], v[k][CRC_W-1:1]};
      v[k+1] = v[k][0] ? (sh[k] ^ poly) : sh[k];
    end
    acc_next = {{BYTE_W{1'b0}}, acc[CRC_W-1:BYTE_W]} ^ v[CRC_BITS_PER_BYTE];
  end

endmodule

@@ design/body_obfuscate_and_checksum_top.sv @@
// Top level of the body obfuscate and checksum block: stream ports, config, state, skid.
//
// Body bytes stream in one beat per cycle while s_tready is high, one result beat each.
// Encode mode adds byte_offset plus the position phase (position modulo cycle_length)
// to the plain byte; decode mode subtracts both to recover it. The plain byte is folded
// into a 32-bit reflected CRC (arithmetic right shift, no final xor, start value zero).
// The beat flagged with tlast carries the checksum and sets tlast on the output; the
// accumulator and phase then clear for the next body. Throughput is one byte per cycle
// while s_tready is high; the eight shift-xor steps run between the input and the
// output register. A two-entry output stage (register plus skid) keeps s_tready
// registered, so input keeps flowing while a result waits. Config writes are taken at
// any time but should only be made between bodies with the output drained.
module body_obfuscate_and_checksum_top import boc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // config write port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              s_tlast,   // last_byte
  // output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // [7:0] result_byte, [39:8] checksum
  output logic              m_tlast    // sum_valid
);

  // config registers
  logic [CRC_W-1:0]   polynomial;
  logic [BYTE_W-1:0]  byte_offset;
  logic [PHASE_W-1:0] cycle_length;
  logic               decode_mode;

  // running state
  logic [CRC_W-1:0]   accumulator;
  logic [PHASE_W-1:0] position_phase;

  // output stage
  boc_beat_t out_beat, skid_beat, new_beat;
  logic      out_valid, skid_valid;

  logic [BYTE_W-1:0]  plain;
  logic [BYTE_W-1:0]  result_byte;
  logic [CRC_W-1:0]   accumulator_next;
  logic [PHASE_W:0]   phase_inc;
  logic [PHASE_W-1:0] position_phase_next;
  logic               accept;
  logic               out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial   <= POLY_RESET;
      byte_offset  <= OFFSET_RESET;
      cycle_length <= CYCLE_RESET;
      decode_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLYNOMIAL:   polynomial   <= cfg_data;
        REG_BYTE_OFFSET:  byte_offset  <= cfg_data[BYTE_W-1:0];
        REG_CYCLE_LENGTH: cycle_length <= cfg_data[PHASE_W-1:0];
        REG_DECODE_MODE:  decode_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // byte transform; the CRC always sees the plain byte
  always_comb begin
    if (decode_mode) begin
      plain       = s_tdata - byte_offset - position_phase;
      result_byte = plain;
    end else begin
      plain       = s_tdata;
      result_byte = s_tdata + byte_offset + position_phase;
    end
  end

  boc_crc_step u_crc (
    .acc      (accumulator),
    .plain    (plain),
    .poly     (polynomial),
    .acc_next (accumulator_next)
  );

  // phase wraps when it reaches cycle_length; a zero length keeps it at zero
  always_comb begin
    phase_inc = {1'b0, position_phase} + {{PHASE_W{1'b0}}, 1'b1};
    if (phase_inc >= {1'b0, cycle_length}) begin
      position_phase_next = '0;
    end else begin
      position_phase_next = phase_inc[PHASE_W-1:0];
    end
  end

  always_comb begin
    new_beat.result_byte = result_byte;
    new_beat.sum_valid   = s_tlast;
    new_beat.checksum    = s_tlast ? accumulator_next : '0;
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      position_phase <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        accumulator    <= '0;
        position_phase <= '0;
      end else begin
        accumulator    <= accumulator_next;
        position_phase <= position_phase_next;
      end
    end
  end

  // output register with skid; skid only fills while the output is held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_beat <= skid_valid ? skid_beat : new_beat;
    end else if (accept) begin
      skid_beat <= new_beat;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_beat.checksum, out_beat.result_byte};
  assign m_tlast  = out_beat.sum_valid;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the body obfuscate and checksum block.
`timescale 1ns / 1ps

module testbench;
  import boc_pkg::*;

  localparam int BEAT_W      = BYTE_W + CRC_W;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  // Running model of the block: its own copy of the registers, the CRC
  // accumulator and the position phase, plus the results still owed.
  class body_crc_board;
    logic [CRC_W-1:0]   poly;
    logic [BYTE_W-1:0]  offset;
    logic [PHASE_W-1:0] cyc_len;
    logic               decode;
    logic [CRC_W-1:0]   crc_acc;
    logic [PHASE_W-1:0] phase;
    boc_beat_t          owed[$];
    int errors;
    int accepted;
    int results;
    int bodies;

    function new();
      poly     = POLY_RESET;
      offset   = OFFSET_RESET;
      cyc_len  = CYCLE_RESET;
      decode   = 1'b0;
      crc_acc  = '0;
      phase    = '0;
      errors   = 0;
      accepted = 0;
      results  = 0;
      bodies   = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_POLYNOMIAL:   poly    = val[CRC_W-1:0];
        REG_BYTE_OFFSET:  offset  = val[BYTE_W-1:0];
        REG_CYCLE_LENGTH: cyc_len = val[PHASE_W-1:0];
        REG_DECODE_MODE:  decode  = val[0];
        default: ;
      endcase
    endfunction

    // Eight reflected steps; the right shift keeps the sign bit.
    function logic [CRC_W-1:0] fold_entry(logic [BYTE_W-1:0] idx);
      logic [CRC_W-1:0] v;
      logic             lsb;
      v = {{(CRC_W-BYTE_W){1'b0}}, idx};
      for (int k = 0; k < CRC_BITS_PER_BYTE; k++) begin
        lsb = v[0];
        v = {v[CRC_W-1], v[CRC_W-1:1]};
        if (lsb) v = v ^ poly;
      end
      return v;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] data, logic last);
      logic [BYTE_W-1:0]  term;
      logic [BYTE_W-1:0]  plain;
      logic [BYTE_W-1:0]  outb;
      boc_beat_t          want;
      int                 nxt;
      term = phase;
      if (decode) begin
        plain = data - offset - term;
        outb  = plain;
      end else begin
        plain = data;
        outb  = data + offset + term;
      end
      crc_acc = {8'd0, crc_acc[CRC_W-1:8]} ^ fold_entry(crc_acc[BYTE_W-1:0] ^ plain);
      // stale phase (length lowered mid-body) is used once, then wraps to 0
      nxt = int'(term) + 1;
      phase = (nxt >= int'(cyc_len)) ? '0 : nxt[PHASE_W-1:0];
      want.result_byte = outb;
      if (last) begin
        want.checksum  = crc_acc;
        want.sum_valid = 1'b1;
        crc_acc = '0;
        phase   = '0;
        bodies++;
      end else begin
        want.checksum  = '0;
        want.sum_valid = 1'b0;
      end
      owed.push_back(want);
      accepted++;
    endfunction

    function void check_beat(logic [BEAT_W-1:0] tdata, logic tlast);
      boc_beat_t want;
      boc_beat_t got;
      got.result_byte = tdata[BYTE_W-1:0];
      got.checksum    = tdata[BEAT_W-1:BYTE_W];
      got.sum_valid   = tlast;
      results++;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected: tdata %h tlast %b",
                 $time, tdata, tlast);
        return;
      end
      want = owed.pop_front();
      if (got.result_byte !== want.result_byte) begin
        errors++;
        $display("%0t: result_byte expected %h actual %h",
                 $time, want.result_byte, got.result_byte);
      end
      if (got.checksum !== want.checksum) begin
        errors++;
        $display("%0t: checksum expected %h actual %h",
                 $time, want.checksum, got.checksum);
      end
      if (got.sum_valid !== want.sum_valid) begin
        errors++;
        $display("%0t: sum_valid expected %b actual %b",
                 $time, want.sum_valid, got.sum_valid);
      end
    endfunction

    function void leftover_check();
      if (owed.size() != 0) begin
        errors++;
        $display("%0t: %0d result beats expected but never seen: next result_byte %h",
                 $time, owed.size(), owed[0].result_byte);
      end
    endfunction
  endclass

  // DUT pins; every input starts at a known value
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;   // [7:0] data_byte
  logic              s_tlast   = 1'b0; // last_byte
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [39:0]       m_tdata;          // [7:0] result_byte, [39:8] checksum
  logic              m_tlast;          // sum_valid

  body_crc_board board = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;   // set by the stimulus, consumed by the receiver
  int hold_left      = 0;
  int hold_max       = 0;
  int settings_count = 0;
  int cycles         = 0;

  body_obfuscate_and_checksum_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** body_obfuscate_and_checksum_top: FAILED **");
    $finish;
  end

  // Receiver. Values read right after the edge are the ones the DUT saw,
  // so a beat counts when m_tvalid and m_tready were both high.
  // m_tready stalls at random, or stays low for a requested hold-off.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_beat(m_tdata, m_tlast);
    if (hold_request > 0) begin
      hold_left = hold_request;
      if (hold_request > hold_max) hold_max = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One input beat; optional idle cycles first, then hold tvalid until taken.
  task automatic send_beat(logic [7:0] data, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    board.note_byte(data, last);
  endtask

  // A run of body bytes; tlast on the final one only when close is set.
  task automatic send_body(int len, bit close);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom_range(255)), close && (i == len - 1));
  endtask

  // Stop offering and wait for every owed result.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  // Single register write; only called with the block drained.
  task automatic program_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic program_all(logic [CRC_W-1:0] poly, logic [7:0] offset,
                             logic [7:0] cyc_len, logic mode);
    program_reg(REG_POLYNOMIAL, poly);
    program_reg(REG_BYTE_OFFSET, {24'd0, offset});
    program_reg(REG_CYCLE_LENGTH, {24'd0, cyc_len});
    program_reg(REG_DECODE_MODE, {31'd0, mode});
    settings_count++;
  endtask

  // Mostly whole bodies with random content; some stray beats with a random
  // tlast, now and then a long body so the phase walks far, and sometimes a
  // body left open across the next register change.
  task automatic random_traffic(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(19))
        0, 1: begin
          send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
          sent++;
        end
        2: begin
          len = $urandom_range(64, 300);
          send_body(len, 1'b1);
          sent += len;
        end
        default: begin
          len = $urandom_range(1, 24);
          send_body(len, 1'b1);
          sent += len;
        end
      endcase
    end
    if ($urandom_range(2) == 0) send_body($urandom_range(1, 10), 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // reset settings: extremes of data, sign-bit and low-bit bytes
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b1);
    drain();
    // all-ones polynomial, max offset and length, decode; one single-byte body
    program_all(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h55, 1'b1);
    drain();
    // sign bit only, so the arithmetic shift smears it; encode wrap past 255
    program_all(32'h8000_0000, 8'hFE, 8'h04, 1'b0);
    send_body(5, 1'b1);
    drain();
    // zero polynomial; cycle length zero acts like one
    program_all(32'h0000_0000, 8'h03, 8'h00, 1'b1);
    send_beat(8'h03, 1'b0);
    send_beat(8'h02, 1'b1);
    drain();
    // length lowered mid-body: stale phase used once, then back to 0
    program_all(POLY_RESET, 8'h10, 8'h08, 1'b0);
    send_body(6, 1'b0);
    drain();
    program_reg(REG_CYCLE_LENGTH, 32'd2);
    send_body(3, 1'b1);
    drain();

    // --- random part: eight settings, four idle patterns ---
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: program_all(POLY_RESET, 8'h00, 8'h01, 1'b0);
        1: program_all(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0);
        2: program_all(32'h8000_0000, 8'($urandom_range(255)), 8'h07, 1'b1);
        3: program_all(32'h0000_0000, 8'($urandom_range(255)),
                       8'($urandom_range(1, 255)), 1'b1);
        6: program_all(POLY_RESET, 8'hFF, 8'hFF, 1'b1);
        default: program_all($urandom, 8'($urandom_range(255)),
                             8'($urandom_range(1) ? $urandom_range(1, 16)
                                                  : $urandom_range(1, 255)),
                             1'($urandom_range(1)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      // long receiver hold-off with the sender pushing flat out
      if (ph == 4) hold_request = HOLD_CYCLES;
      random_traffic(190);
    end

    // --- wind down ---
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    board.leftover_check();

    $display("Covered %0d input beats and %0d result beats, %0d checksummed bodies,",
             board.accepted, board.results, board.bodies);
    $display("over %0d register settings; longest output hold-off %0d cycles.",
             settings_count + 1, hold_max);
    if (board.errors == 0) begin
      $display("** body_obfuscate_and_checksum_top: PASSED **");
    end else begin
      $display("** body_obfuscate_and_checksum_top: FAILED **");
    end
    $finish;
  end

endmodule
